FILE: design/chu_pkg.sv
// ============================================================================
// chu_pkg - shared types and constants for the color usage histogram RAM
// Field widths, window geometry, operation codes and the controller/datapath
// command and status bundles.
// ============================================================================
`default_nettype none

package chu_pkg;

  // Field and storage widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 16;
  localparam int WORD_W   = 16;
  localparam int PIX_W    = 8;
  localparam int COLOR_W  = 8;
  localparam int ROW_W    = 8;
  localparam int COUNT_W  = 17;
  localparam int OFFSET_W = ADDR_W + 1;

  localparam int NUM_WORDS  = 1 << ADDR_W;
  localparam int NUM_COLORS = 1 << COLOR_W;
  localparam int NUM_ROWS   = 1 << ROW_W;

  // Visible window geometry, in pixels (one pixel per byte)
  localparam int VISIBLE_WIDTH  = 344;
  localparam int VISIBLE_HEIGHT = 240;
  localparam int ROW_BYTES      = 512;

  // Color 0 starts out covering the whole window
  localparam logic [COUNT_W-1:0] AREA_COUNT =
    COUNT_W'((VISIBLE_WIDTH * VISIBLE_HEIGHT) % (1 << COUNT_W));

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic sweep;       // clear one entry of every store
    logic accept;      // capture the transaction and issue all reads
    logic word_check;  // merge bytes, store the word and set the row dirty if changed
    logic hist_rd;     // read the count of the current histogram step
    logic hist_wr;     // write back the adjusted count
    logic step_next;   // advance the histogram step
    logic dirty_clr;   // clear the tested row's dirty flag
    logic res_push;    // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic            sweep_last;
    logic [OP_W-1:0] op;
    logic            changed;
    logic            visible;
    logic            step_last;
    logic            out_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/chu_if.sv
// ============================================================================
// chu_if - valid/ready channels of the color usage histogram RAM
// Request channel (operation and its operands) and result channel.
// ============================================================================
`default_nettype none

interface chu_in_if;
  logic                         valid;
  logic                         ready;
  logic [chu_pkg::OP_W-1:0]     operation;
  logic [chu_pkg::ADDR_W-1:0]   word_address;
  logic [chu_pkg::WORD_W-1:0]   write_data;
  logic                         write_high;
  logic                         write_low;
  logic [chu_pkg::COLOR_W-1:0]  color_index;
  logic [chu_pkg::ROW_W-1:0]    row_index;

  modport source (
    output valid, operation, word_address, write_data, write_high, write_low,
           color_index, row_index,
    input  ready
  );
  modport sink (
    input  valid, operation, word_address, write_data, write_high, write_low,
           color_index, row_index,
    output ready
  );
endinterface

interface chu_out_if;
  logic                         valid;
  logic                         ready;
  logic                         word_changed;
  logic [chu_pkg::COUNT_W-1:0]  color_count;
  logic                         color_used;
  logic                         row_was_dirty;

  modport source (
    output valid, word_changed, color_count, color_used, row_was_dirty,
    input  ready
  );
  modport sink (
    input  valid, word_changed, color_count, color_used, row_was_dirty,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/chu_datapath.sv
// ============================================================================
// chu_datapath - stores, histogram arithmetic and result register
// Holds the pixel word RAM, the color count RAM and the row dirty RAM, and
// carries out the steps the controller commands.
// ============================================================================
`default_nettype none

module chu_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire chu_pkg::cmd_t               cmd,
  output chu_pkg::sts_t                    sts,
  input  wire logic [chu_pkg::OP_W-1:0]    in_operation,
  input  wire logic [chu_pkg::ADDR_W-1:0]  in_word_address,
  input  wire logic [chu_pkg::WORD_W-1:0]  in_write_data,
  input  wire logic                        in_write_high,
  input  wire logic                        in_write_low,
  input  wire logic [chu_pkg::COLOR_W-1:0] in_color_index,
  input  wire logic [chu_pkg::ROW_W-1:0]   in_row_index,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic                             out_word_changed,
  output logic [chu_pkg::COUNT_W-1:0]      out_color_count,
  output logic                             out_color_used,
  output logic                             out_row_was_dirty
);

  // Stores
  logic [chu_pkg::WORD_W-1:0]  pix_mem   [chu_pkg::NUM_WORDS];
  logic [chu_pkg::COUNT_W-1:0] hist_mem  [chu_pkg::NUM_COLORS];
  logic                        dirty_mem [chu_pkg::NUM_ROWS];

  logic [chu_pkg::WORD_W-1:0]  pix_rdata_r;
  logic [chu_pkg::COUNT_W-1:0] hist_rdata_r;
  logic                        dirty_rdata_r;

  // Captured transaction
  logic [chu_pkg::OP_W-1:0]    op_r;
  logic [chu_pkg::ADDR_W-1:0]  addr_r;
  logic [chu_pkg::WORD_W-1:0]  data_r;
  logic                        wr_hi_r;
  logic                        wr_lo_r;
  logic [chu_pkg::ROW_W-1:0]   row_r;

  logic [chu_pkg::WORD_W-1:0]  oldw_r;
  logic [chu_pkg::WORD_W-1:0]  neww_r;
  logic                        changed_r;
  logic [1:0]                  step_r;
  logic [chu_pkg::ADDR_W-1:0]  sweep_idx_r;
  logic                        out_valid_r;

  logic [chu_pkg::WORD_W-1:0]   mask;
  logic [chu_pkg::WORD_W-1:0]   neww;
  logic                         changed;
  logic [chu_pkg::OFFSET_W-1:0] offset;
  logic [chu_pkg::OFFSET_W-1:0] xpos;
  logic [chu_pkg::OFFSET_W-1:0] ypos;
  logic                         visible;
  logic [chu_pkg::COLOR_W-1:0]  step_color;
  logic [chu_pkg::COUNT_W-1:0]  step_delta;
  logic [chu_pkg::COUNT_W-1:0]  sweep_count;

  // Byte merge and change detect
  assign mask    = {{chu_pkg::PIX_W{wr_hi_r}}, {chu_pkg::PIX_W{wr_lo_r}}};
  assign neww    = (pix_rdata_r & ~mask) | (data_r & mask);
  assign changed = (neww != pix_rdata_r);

  // Window position of the word (two pixels per word)
  assign offset  = {addr_r, 1'b0};
  assign xpos    = chu_pkg::OFFSET_W'(offset % chu_pkg::ROW_BYTES);
  assign ypos    = chu_pkg::OFFSET_W'(offset / chu_pkg::ROW_BYTES);
  assign visible = (xpos < chu_pkg::OFFSET_W'(chu_pkg::VISIBLE_WIDTH)) &&
                   (ypos < chu_pkg::OFFSET_W'(chu_pkg::VISIBLE_HEIGHT));

  // Histogram steps: drop both old colors, then add both new colors
  always_comb begin
    unique case (step_r)
      2'd0:    step_color = oldw_r[chu_pkg::WORD_W-1:chu_pkg::PIX_W];
      2'd1:    step_color = oldw_r[chu_pkg::PIX_W-1:0];
      2'd2:    step_color = neww_r[chu_pkg::WORD_W-1:chu_pkg::PIX_W];
      default: step_color = neww_r[chu_pkg::PIX_W-1:0];
    endcase
  end
  assign step_delta  = step_r[1] ? chu_pkg::COUNT_W'(1) : '1;
  assign sweep_count = (sweep_idx_r[chu_pkg::COLOR_W-1:0] == '0) ? chu_pkg::AREA_COUNT : '0;

  // Pixel word RAM
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      pix_mem[sweep_idx_r] <= '0;
    end else if (cmd.word_check && changed) begin
      pix_mem[addr_r] <= neww;
    end
    if (cmd.accept) begin
      pix_rdata_r <= pix_mem[in_word_address];
    end
  end

  // Color count RAM
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      hist_mem[sweep_idx_r[chu_pkg::COLOR_W-1:0]] <= sweep_count;
    end else if (cmd.hist_wr) begin
      hist_mem[step_color] <= hist_rdata_r + step_delta;
    end
    if (cmd.accept) begin
      hist_rdata_r <= hist_mem[in_color_index];
    end else if (cmd.hist_rd) begin
      hist_rdata_r <= hist_mem[step_color];
    end
  end

  // Row dirty RAM
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      dirty_mem[sweep_idx_r[chu_pkg::ROW_W-1:0]] <= 1'b0;
    end else if (cmd.word_check && changed) begin
      dirty_mem[ypos[chu_pkg::ROW_W-1:0]] <= 1'b1;
    end else if (cmd.dirty_clr) begin
      dirty_mem[row_r] <= 1'b0;
    end
    if (cmd.accept) begin
      dirty_rdata_r <= dirty_mem[in_row_index];
    end
  end

  // Transaction capture and word merge results
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_operation;
      addr_r  <= in_word_address;
      data_r  <= in_write_data;
      wr_hi_r <= in_write_high;
      wr_lo_r <= in_write_low;
      row_r   <= in_row_index;
    end
    if (cmd.word_check) begin
      oldw_r <= pix_rdata_r;
      neww_r <= neww;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_idx_r <= '0;
      step_r      <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_idx_r <= sweep_idx_r + 1'b1;
      end
      if (cmd.accept) begin
        step_r    <= '0;
        changed_r <= 1'b0;
      end else begin
        if (cmd.step_next) begin
          step_r <= step_r + 1'b1;
        end
        if (cmd.word_check) begin
          changed_r <= changed;
        end
      end
      if (cmd.res_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_push) begin
      out_word_changed  <= (op_r == chu_pkg::OP_WRITE) && changed_r;
      out_color_count   <= (op_r == chu_pkg::OP_QUERY) ? hist_rdata_r : '0;
      out_color_used    <= (op_r == chu_pkg::OP_QUERY) && (hist_rdata_r != '0);
      out_row_was_dirty <= (op_r == chu_pkg::OP_TEST) && dirty_rdata_r;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.sweep_last = &sweep_idx_r;
  assign sts.op         = op_r;
  assign sts.changed    = changed;
  assign sts.visible    = visible;
  assign sts.step_last  = (step_r == 2'd3);
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

`default_nettype wire

FILE: design/chu_ctrl.sv
// ============================================================================
// chu_ctrl - sequencer of the color usage histogram RAM
// Runs the clearing pass after reset, then steps each transaction through
// decode, the histogram read-modify-writes and the result hand-off.
// ============================================================================
`default_nettype none

module chu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire chu_pkg::sts_t sts,
  output chu_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_SWEEP  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_HRD    = 3'd3;
  localparam logic [2:0] S_HWR    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FIN;
        unique case (sts.op)
          chu_pkg::OP_WRITE: begin
            cmd.word_check = 1'b1;
            if (sts.changed && sts.visible) begin
              state_nxt = S_HRD;
            end
          end
          chu_pkg::OP_TEST: begin
            cmd.dirty_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_HRD: begin
        cmd.hist_rd = 1'b1;
        state_nxt   = S_HWR;
      end
      S_HWR: begin
        cmd.hist_wr   = 1'b1;
        cmd.step_next = 1'b1;
        state_nxt     = sts.step_last ? S_FIN : S_HRD;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.res_push = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/color_usage_histogram_ram.sv
// ============================================================================
// color_usage_histogram_ram - bitmap RAM with a per-color usage histogram
// Top level: request and result channels, sequencer and datapath.
// ============================================================================
// After reset the block runs a clearing pass (one pixel word per cycle; the
// color counts and row dirty flags are cleared in the same pass) and accepts
// no transaction until it ends. It then takes one request at a time. A query
// or a row test goes from acceptance through decode to the result hand-off,
// as does a write that leaves the stored word unchanged or lands outside the
// visible window. A write that changes a visible word also goes through four
// read-modify-writes of the single-port color count RAM, each a read state
// and a write state, before the hand-off. A finished result sits in the
// output register, and the block accepts the next request while it waits
// there; a second result waits inside the block until the first is taken.
// ============================================================================
`default_nettype none

module color_usage_histogram_ram (
  input  wire logic  clk,
  input  wire logic  rst_n,
  chu_in_if.sink     in_chan,
  chu_out_if.source  out_chan
);

  chu_pkg::cmd_t cmd;
  chu_pkg::sts_t sts;

  // Sequencer: clearing pass, decode, histogram steps, result hand-off
  chu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: the three RAMs, byte merge, window test, count adjust
  chu_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_chan.operation),
    .in_word_address   (in_chan.word_address),
    .in_write_data     (in_chan.write_data),
    .in_write_high     (in_chan.write_high),
    .in_write_low      (in_chan.write_low),
    .in_color_index    (in_chan.color_index),
    .in_row_index      (in_chan.row_index),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_word_changed  (out_chan.word_changed),
    .out_color_count   (out_chan.color_count),
    .out_color_used    (out_chan.color_used),
    .out_row_was_dirty (out_chan.row_was_dirty)
  );

  // One transaction in flight: acceptance drops ready on the next cycle
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted while another is in flight");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_push |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten");

  // Every count write-back follows the read of the same step
  a_hist_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_wr |-> $past(cmd.hist_rd))
    else $error("count write without preceding read");

  // Used flag agrees with the count it comes from
  a_used_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.color_used == (out_chan.color_count != '0)))
    else $error("color_used disagrees with color_count");

endmodule

`default_nettype wire
